FILE: hdl/jwf_pkg.sv
// Shared constants, types and command/status bundles of the joint waypoint feeder.
`timescale 1ns / 1ps
package jwf_pkg;

	localparam int QUEUE_POINTS = 256;
	localparam int JOINTS       = 6;
	localparam int BASE_JOINTS  = 3;
	localparam int ANGLE_W      = 24;
	localparam int MAX_RESULTS  = 64;

	localparam int TF_W    = 7;
	localparam int FR_W    = 10;
	localparam int MS_W    = 23;
	localparam int CFG_W   = 23;
	localparam int CIDX_W  = 2;
	localparam int WORDS_W = 16;
	localparam int BATCH_W = 32;

	localparam int QI_W    = $clog2(QUEUE_POINTS);
	localparam int CNT_W   = $clog2(QUEUE_POINTS + 1);
	localparam int ROW_W   = JOINTS * ANGLE_W;
	localparam int JSEL_W  = $clog2(JOINTS);
	localparam int NEED_W  = $clog2(MAX_RESULTS + 1);

	// |delta| width, parts count width and interpolation numerator width
	localparam int AD_W    = ANGLE_W;
	localparam int N_W     = AD_W + FR_W + 1;
	localparam int PROD_W  = AD_W + N_W;
	localparam int DCNT_W  = $clog2(N_W);

	// ceil(words/6) as floor((words+5)*43691 >> 18), exact below 2^17
	localparam int DIV6_MUL   = 43691;
	localparam int DIV6_MUL_W = 16;
	localparam int DIV6_SH    = 18;
	localparam int W5_W       = WORDS_W + 1;
	localparam int P6_W       = W5_W + DIV6_MUL_W;
	localparam int C6_W       = P6_W - DIV6_SH;
	localparam int DIFF_W     = C6_W + 1;

	localparam logic [CIDX_W-1:0] CFG_TARGET_FILL     = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_RATE      = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX_SPEED_BASE  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_MAX_SPEED_WRIST = 2'd3;

	localparam logic CMD_PLAN   = 1'b0;
	localparam logic CMD_REFILL = 1'b1;

	localparam logic [TF_W-1:0] TF_RESET = 7'd32;
	localparam logic [FR_W-1:0] FR_RESET = 10'd200;
	localparam logic [MS_W-1:0] MSB_RESET = 23'd2722289;
	localparam logic [MS_W-1:0] MSW_RESET = 23'd3261257;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_PDIV_GO,
		ST_PDIV_WAIT,
		ST_STEP,
		ST_QDIV_GO,
		ST_QDIV_WAIT,
		ST_ADV,
		ST_EMIT,
		ST_FINISH
	} jwf_state_t;

	typedef struct packed {
		logic plan_wr;
		logic refill_start;
		logic seg_start;
		logic pdiv_go;
		logic pdiv_take;
		logic step;
		logic qdiv_go;
		logic qdiv_take;
		logic adv;
		logic hold;
		logic out_take;
		logic finish;
	} jwf_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic k_zero;
		logic jsel_last;
		logic div_busy;
		logic emit_done;
	} jwf_stat_t;

endpackage

FILE: hdl/jwf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jwf_div import jwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [N_W-1:0]    den,
	output logic              busy,
	output logic [N_W-1:0]    quo
);

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [N_W-1:0]    rem_q;
	logic [N_W-1:0]    lo_q;
	logic [N_W-1:0]    den_q;
	logic [N_W-1:0]    quo_q;
	logic [N_W:0]      trial;
	logic [N_W:0]      diff;
	logic              fits;

	assign trial = {rem_q, lo_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(N_W - 1))
				busy_q <= 1'b0;
		end
	end

	// quotient is known to fit N_W bits, so the top part starts as remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(N_W - AD_W){1'b0}}, num[PROD_W-1:N_W]};
			lo_q  <= num[N_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
			lo_q  <= {lo_q[N_W-2:0], 1'b0};
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/jwf_datapath.sv
// Queue memory, working registers and arithmetic of the waypoint feeder.
`timescale 1ns / 1ps
module jwf_datapath import jwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  jwf_cmd_t           cmd,
	output jwf_stat_t          stat,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]   cfg_data,
	input  angle_t             pt [JOINTS],
	input  logic               plan_first,
	input  logic               plan_last,
	input  logic [WORDS_W-1:0] buffered_words,
	output angle_t             last [JOINTS],
	output logic               held,
	output logic               batch_end
);

	logic [ROW_W-1:0] mem [QUEUE_POINTS];
	logic [ROW_W-1:0] rd_row_q;

	logic [TF_W-1:0]    tf_q;
	logic [FR_W-1:0]    fr_q;
	logic [MS_W-1:0]    msb_q;
	logic [MS_W-1:0]    msw_q;
	logic [QI_W-1:0]    head_q;
	logic [CNT_W-1:0]   count_q;
	logic [BATCH_W-1:0] batch_q;
	logic [BATCH_W-1:0] tag_q;
	logic [NEED_W-1:0]  need_q;
	logic [NEED_W-1:0]  emitted_q;
	logic [N_W-1:0]     k_q;
	logic [JSEL_W-1:0]  jsel_q;
	logic               held_q;

	angle_t            prev_q [JOINTS];
	angle_t            pre_q  [JOINTS];
	angle_t            last_q [JOINTS];
	angle_t            nxt    [JOINTS];
	logic [AD_W-1:0]   ad_q   [JOINTS];
	logic              neg_q  [JOINTS];
	logic [PROD_W-1:0] prod_q [JOINTS];
	logic [N_W-1:0]    nmax_q;
	logic [N_W-1:0]    n_q;

	// plan write path
	logic             clear_plan;
	logic [QI_W-1:0]  head_eff;
	logic [CNT_W-1:0] count_eff;
	logic [CNT_W:0]   slot_sum;
	logic [QI_W-1:0]  slot;
	logic             room;
	logic [ROW_W-1:0] row_in;

	// refill length
	logic [W5_W-1:0]          words_p5;
	logic [P6_W-1:0]          prod6;
	logic [C6_W-1:0]          ceil6;
	logic signed [DIFF_W-1:0] need_diff;
	logic [NEED_W-1:0]        need_next;

	// divider operands
	logic [AD_W-1:0]      ad_sel;
	logic [MS_W-1:0]      ms_sel;
	logic [MS_W-1:0]      ms_eff;
	logic [AD_W+FR_W-1:0] pmul;
	logic [N_W-1:0]       pnum;
	logic [PROD_W-1:0]    qnum;
	logic [PROD_W-1:0]    div_num;
	logic [N_W-1:0]       div_den;
	logic                 div_busy;
	logic [N_W-1:0]       quo;
	logic [N_W-1:0]       nmax_new;
	logic signed [ANGLE_W+1:0] part_res;
	logic                 jsel_last;

	assign clear_plan = plan_first && (tag_q != batch_q);
	assign head_eff   = clear_plan ? '0 : head_q;
	assign count_eff  = clear_plan ? '0 : count_q;
	assign slot_sum   = {1'b0, count_eff} + (CNT_W + 1)'(head_eff);
	assign slot       = (slot_sum >= (CNT_W + 1)'(QUEUE_POINTS)) ?
		QI_W'(slot_sum - (CNT_W + 1)'(QUEUE_POINTS)) : QI_W'(slot_sum);
	assign room       = count_eff < CNT_W'(QUEUE_POINTS);

	always_comb begin
		for (int j = 0; j < JOINTS; j++) begin
			row_in[j*ANGLE_W +: ANGLE_W] = pt[j];
			nxt[j] = angle_t'(rd_row_q[j*ANGLE_W +: ANGLE_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.plan_wr && room)
			mem[slot] <= row_in;
	end

	always_ff @(posedge clk) begin
		rd_row_q <= mem[head_q];
	end

	assign words_p5  = {1'b0, buffered_words} + W5_W'(5);
	assign prod6     = P6_W'(words_p5) * P6_W'(DIV6_MUL);
	assign ceil6     = prod6[P6_W-1:DIV6_SH];
	assign need_diff = $signed(DIFF_W'(tf_q)) - $signed({1'b0, ceil6});

	always_comb begin
		if (need_diff <= 0)
			need_next = '0;
		else if (need_diff > DIFF_W'(MAX_RESULTS))
			need_next = NEED_W'(MAX_RESULTS);
		else
			need_next = need_diff[NEED_W-1:0];
	end

	assign jsel_last = jsel_q == JSEL_W'(JOINTS - 1);
	assign ad_sel    = ad_q[jsel_q];
	assign ms_sel    = (jsel_q < JSEL_W'(BASE_JOINTS)) ? msb_q : msw_q;
	assign ms_eff    = (ms_sel == '0) ? MS_W'(1) : ms_sel;
	assign pmul      = (AD_W + FR_W)'(ad_sel) * (AD_W + FR_W)'(fr_q);
	assign pnum      = N_W'(pmul) + N_W'(ms_eff) - N_W'(1);
	assign qnum      = prod_q[jsel_q] + PROD_W'(n_q >> 1);
	assign div_num   = cmd.pdiv_go ? PROD_W'(pnum) : qnum;
	assign div_den   = cmd.pdiv_go ? N_W'(ms_eff) : n_q;
	assign nmax_new  = (quo > nmax_q) ? quo : nmax_q;

	always_comb begin
		if (neg_q[jsel_q])
			part_res = (ANGLE_W + 2)'(pre_q[jsel_q]) -
				$signed({2'b00, quo[AD_W-1:0]});
		else
			part_res = (ANGLE_W + 2)'(pre_q[jsel_q]) +
				$signed({2'b00, quo[AD_W-1:0]});
	end

	jwf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.pdiv_go || cmd.qdiv_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q      <= TF_RESET;
			fr_q      <= FR_RESET;
			msb_q     <= MSB_RESET;
			msw_q     <= MSW_RESET;
			head_q    <= '0;
			count_q   <= '0;
			batch_q   <= '0;
			tag_q     <= '0;
			need_q    <= '0;
			emitted_q <= '0;
			k_q       <= '0;
			jsel_q    <= '0;
			held_q    <= 1'b0;
			for (int j = 0; j < JOINTS; j++)
				prev_q[j] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TARGET_FILL:     tf_q  <= cfg_data[TF_W-1:0];
					CFG_FRAME_RATE:      fr_q  <= cfg_data[FR_W-1:0];
					CFG_MAX_SPEED_BASE:  msb_q <= cfg_data[MS_W-1:0];
					CFG_MAX_SPEED_WRIST: msw_q <= cfg_data[MS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.plan_wr) begin
				head_q  <= head_eff;
				count_q <= room ? count_eff + 1'b1 : count_eff;
				if (plan_last) begin
					tag_q <= batch_q;
					for (int j = 0; j < JOINTS; j++)
						prev_q[j] <= pt[j];
				end
			end
			if (cmd.refill_start) begin
				if (tag_q != batch_q) begin
					head_q  <= '0;
					count_q <= '0;
				end
				need_q    <= need_next;
				emitted_q <= '0;
				k_q       <= '0;
			end
			if (cmd.seg_start)
				jsel_q <= '0;
			if (cmd.pdiv_take || cmd.qdiv_take)
				jsel_q <= jsel_last ? '0 : jsel_q + 1'b1;
			if (cmd.step) begin
				k_q    <= k_q + 1'b1;
				jsel_q <= '0;
			end
			if (cmd.adv) begin
				held_q <= 1'b0;
				if (k_q == n_q) begin
					k_q     <= '0;
					head_q  <= (head_q == QI_W'(QUEUE_POINTS - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.hold)
				held_q <= 1'b1;
			if (cmd.out_take)
				emitted_q <= emitted_q + 1'b1;
			if (cmd.finish && emitted_q != '0) begin
				batch_q <= batch_q + 1'b1;
				for (int j = 0; j < JOINTS; j++)
					prev_q[j] <= last_q[j];
			end
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (cmd.refill_start) begin
			for (int j = 0; j < JOINTS; j++)
				pre_q[j] <= prev_q[j];
		end
		if (cmd.seg_start) begin
			nmax_q <= N_W'(1);
			for (int j = 0; j < JOINTS; j++) begin
				logic signed [ANGLE_W:0] d;
				d = (ANGLE_W + 1)'(nxt[j]) - (ANGLE_W + 1)'(pre_q[j]);
				neg_q[j]  <= d[ANGLE_W];
				ad_q[j]   <= d[ANGLE_W] ? AD_W'(-d) : AD_W'(d);
				prod_q[j] <= '0;
			end
		end
		if (cmd.pdiv_take) begin
			nmax_q <= nmax_new;
			if (jsel_last)
				n_q <= nmax_new;
		end
		if (cmd.step) begin
			for (int j = 0; j < JOINTS; j++)
				prod_q[j] <= prod_q[j] + PROD_W'(ad_q[j]);
		end
		if (cmd.qdiv_take)
			last_q[jsel_q] <= part_res[ANGLE_W-1:0];
		if (cmd.adv && k_q == n_q) begin
			for (int j = 0; j < JOINTS; j++)
				pre_q[j] <= nxt[j];
		end
		if (cmd.hold) begin
			for (int j = 0; j < JOINTS; j++)
				last_q[j] <= pre_q[j];
		end
	end

	assign stat.count_zero = count_q == '0;
	assign stat.k_zero     = k_q == '0;
	assign stat.jsel_last  = jsel_last;
	assign stat.div_busy   = div_busy;
	assign stat.emit_done  = emitted_q == need_q;

	assign last      = last_q;
	assign held      = held_q;
	assign batch_end = (emitted_q + 1'b1) == need_q;

endmodule

FILE: hdl/jwf_ctrl.sv
// Sequencer of the waypoint feeder: handshakes and datapath commands.
`timescale 1ns / 1ps
module jwf_ctrl import jwf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      command,
	output logic      out_valid,
	input  logic      out_ready,
	input  jwf_stat_t stat,
	output jwf_cmd_t  cmd
);

	jwf_state_t state_q;
	jwf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && command == CMD_REFILL)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.emit_done)
					state_d = ST_FINISH;
				else if (stat.count_zero)
					state_d = ST_EMIT;
				else
					state_d = ST_LOAD;
			end
			ST_LOAD:      state_d = stat.k_zero ? ST_PDIV_GO : ST_STEP;
			ST_PDIV_GO:   state_d = ST_PDIV_WAIT;
			ST_PDIV_WAIT: begin
				if (!stat.div_busy)
					state_d = stat.jsel_last ? ST_STEP : ST_PDIV_GO;
			end
			ST_STEP:      state_d = ST_QDIV_GO;
			ST_QDIV_GO:   state_d = ST_QDIV_WAIT;
			ST_QDIV_WAIT: begin
				if (!stat.div_busy)
					state_d = stat.jsel_last ? ST_ADV : ST_QDIV_GO;
			end
			ST_ADV:       state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready)
					state_d = ST_CHECK;
			end
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.plan_wr      = in_valid && command == CMD_PLAN;
				cmd.refill_start = in_valid && command == CMD_REFILL;
			end
			ST_CHECK:     cmd.hold      = !stat.emit_done && stat.count_zero;
			ST_LOAD:      cmd.seg_start = stat.k_zero;
			ST_PDIV_GO:   cmd.pdiv_go   = 1'b1;
			ST_PDIV_WAIT: cmd.pdiv_take = !stat.div_busy;
			ST_STEP:      cmd.step      = 1'b1;
			ST_QDIV_GO:   cmd.qdiv_go   = 1'b1;
			ST_QDIV_WAIT: cmd.qdiv_take = !stat.div_busy;
			ST_ADV:       cmd.adv       = 1'b1;
			ST_EMIT: begin
				out_valid    = 1'b1;
				cmd.out_take = out_ready;
			end
			ST_FINISH:    cmd.finish    = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hdl/joint_waypoint_feeder_core.sv
// Top level of the joint waypoint feeder: sequencer plus datapath.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid/in_ready, command, joint_a*, | into block
//          | plan_first, plan_last, buffered_words |
//  out     | out_valid/out_ready, out_a*,          | out of block
//          | batch_end, held                       |
//  cfg     | cfg_we, cfg_idx, cfg_data             | into block
//
// A plan-point transaction is taken in the idle state, which stays ready. Per
// refill result: an empty queue repeats the held pose; else a new segment
// first runs one parts division per joint, then a step, one interpolation
// division per joint and an advance; the shared one-bit-per-cycle divider does both.
// Reset clears all control state at once; the queue memory needs no clearing
// pass, its fill count marks valid entries. A stalled result holds the block.
`timescale 1ns / 1ps
module joint_waypoint_feeder_core import jwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [ANGLE_W-1:0] joint_a0,
	input  logic [ANGLE_W-1:0] joint_a1,
	input  logic [ANGLE_W-1:0] joint_a2,
	input  logic [ANGLE_W-1:0] joint_a3,
	input  logic [ANGLE_W-1:0] joint_a4,
	input  logic [ANGLE_W-1:0] joint_a5,
	input  logic               plan_first,
	input  logic               plan_last,
	input  logic [WORDS_W-1:0] buffered_words,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] out_a0,
	output logic [ANGLE_W-1:0] out_a1,
	output logic [ANGLE_W-1:0] out_a2,
	output logic [ANGLE_W-1:0] out_a3,
	output logic [ANGLE_W-1:0] out_a4,
	output logic [ANGLE_W-1:0] out_a5,
	output logic               batch_end,
	output logic               held
);

	jwf_cmd_t  cmd;
	jwf_stat_t stat;
	angle_t    pt   [JOINTS];
	angle_t    last [JOINTS];

	// gather the joint fields into one point
	assign pt[0] = angle_t'(joint_a0);
	assign pt[1] = angle_t'(joint_a1);
	assign pt[2] = angle_t'(joint_a2);
	assign pt[3] = angle_t'(joint_a3);
	assign pt[4] = angle_t'(joint_a4);
	assign pt[5] = angle_t'(joint_a5);

	jwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	jwf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.pt             (pt),
		.plan_first     (plan_first),
		.plan_last      (plan_last),
		.buffered_words (buffered_words),
		.last           (last),
		.held           (held),
		.batch_end      (batch_end)
	);

	// drive the setpoint fields from the output registers
	assign out_a0 = last[0];
	assign out_a1 = last[1];
	assign out_a2 = last[2];
	assign out_a3 = last[3];
	assign out_a4 = last[4];
	assign out_a5 = last[5];

`ifndef NO_ASSERTIONS
	// input and output sides are never open together
	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is offered");

	// a plan-point transaction leaves the block ready again
	a_plan_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_PLAN) |=> in_ready)
		else $error("plan point did not complete in one cycle");

	// after the last result of a batch no result follows at once
	a_batch_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && batch_end) |=> !out_valid)
		else $error("result offered right after batch end");
`endif

endmodule

FILE: sim/tb_joint_waypoint_feeder_core.sv
// Self-checking testbench of the joint waypoint feeder core.
`timescale 1ns / 1ps
module tb_joint_waypoint_feeder_core;
	import jwf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	// A refill that yields nothing still keeps the sequencer busy for a while.
	localparam int DRAIN_CYCLES = 600;

	typedef struct {
		logic [ANGLE_W-1:0] a [JOINTS];
		logic               last_of_batch;
		logic               repeat_flag;
	} setpoint_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CIDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic [ANGLE_W-1:0] joint_a0, joint_a1, joint_a2, joint_a3, joint_a4, joint_a5;
	logic               plan_first;
	logic               plan_last;
	logic [WORDS_W-1:0] buffered_words;
	logic               out_valid;
	logic               out_ready;
	logic [ANGLE_W-1:0] out_a0, out_a1, out_a2, out_a3, out_a4, out_a5;
	logic               batch_end;
	logic               held;

	joint_waypoint_feeder_core dut (.*);

	// Mirror of the block: point queue, last setpoint, batch bookkeeping, registers.
	longint      pt_mem [QUEUE_POINTS][JOINTS];
	int unsigned pt_head;
	int unsigned pt_count;
	longint      last_sp [JOINTS];
	logic [31:0] batch_num;
	logic [31:0] plan_batch;
	int unsigned fill_goal;
	int unsigned servo_hz;
	int unsigned speed_base;
	int unsigned speed_wrist;
	// Walking position inside a refill.
	longint      last_sp_pre [JOINTS];

	setpoint_t   setpoint_q [$];
	int          fail_count;
	int          idle_cycles;
	bit          gaps_on;

	// Clock and reset: reset starts asserted and is released on a rising clock edge.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_joint_waypoint_feeder_core failed");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return gaps_on ? $urandom_range(0, 6) : 0;
	endfunction

	// Parts needed so every joint stays under its speed limit.
	function automatic longint unsigned segment_parts(longint nxt [JOINTS]);
		longint unsigned n, ad, lim, p;
		n = 1;
		for (int j = 0; j < JOINTS; j++) begin
			ad  = (nxt[j] >= last_sp_pre[j]) ? nxt[j] - last_sp_pre[j] : last_sp_pre[j] - nxt[j];
			lim = (j < BASE_JOINTS) ? speed_base : speed_wrist;
			if (lim == 0)
				lim = 1;
			p = (ad * servo_hz + lim - 1) / lim;
			if (p > n)
				n = p;
		end
		return n;
	endfunction

	function automatic longint interp(longint from, longint to, longint unsigned k,
			longint unsigned n);
		longint          d;
		longint unsigned q;
		d = to - from;
		q = ((d < 0 ? -d : d) * k + n / 2) / n;
		return d < 0 ? from - longint'(q) : from + longint'(q);
	endfunction

	// Apply one accepted transaction to the mirror and queue its setpoints.
	task automatic predict_item(logic cmd, longint pt [JOINTS], logic first, logic fin,
			logic [WORDS_W-1:0] words);
		int              need;
		longint          cur [JOINTS];
		longint          nxt [JOINTS];
		longint unsigned k, n;
		setpoint_t       sp;
		if (cmd == CMD_PLAN) begin
			if (first && plan_batch != batch_num) begin
				pt_head  = 0;
				pt_count = 0;
			end
			if (pt_count < QUEUE_POINTS) begin
				pt_mem[(pt_head + pt_count) % QUEUE_POINTS] = pt;
				pt_count++;
			end
			if (fin) begin
				last_sp    = pt;
				plan_batch = batch_num;
			end
			return;
		end
		if (plan_batch != batch_num) begin
			pt_head  = 0;
			pt_count = 0;
		end
		need = int'(fill_goal) - int'((int'(words) + 5) / 6);
		if (need > MAX_RESULTS)
			need = MAX_RESULTS;
		last_sp_pre = last_sp;
		cur = last_sp;
		k = 0;
		n = 1;
		for (int e = 0; e < need; e++) begin
			if (pt_count == 0) begin
				cur = last_sp_pre;
				sp.repeat_flag = 1'b1;
			end else begin
				nxt = pt_mem[pt_head];
				if (k == 0)
					n = segment_parts(nxt);
				k++;
				for (int j = 0; j < JOINTS; j++)
					cur[j] = interp(last_sp_pre[j], nxt[j], k, n);
				if (k == n) begin
					last_sp_pre = nxt;
					pt_head  = (pt_head + 1) % QUEUE_POINTS;
					pt_count--;
					k = 0;
				end
				sp.repeat_flag = 1'b0;
			end
			for (int j = 0; j < JOINTS; j++)
				sp.a[j] = cur[j][ANGLE_W-1:0];
			sp.last_of_batch = (e == need - 1);
			setpoint_q.insert(setpoint_q.size(), sp);
		end
		if (need > 0) begin
			last_sp = cur;
			batch_num++;
		end
	endtask

	// Send one transaction; valid stays up after acceptance unless a gap follows.
	task automatic send_item(logic cmd, longint pt [JOINTS], logic first, logic fin,
			logic [WORDS_W-1:0] words);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		joint_a0       <= pt[0][ANGLE_W-1:0];
		joint_a1       <= pt[1][ANGLE_W-1:0];
		joint_a2       <= pt[2][ANGLE_W-1:0];
		joint_a3       <= pt[3][ANGLE_W-1:0];
		joint_a4       <= pt[4][ANGLE_W-1:0];
		joint_a5       <= pt[5][ANGLE_W-1:0];
		plan_first     <= first;
		plan_last      <= fin;
		buffered_words <= words;
		do @(posedge clk); while (!in_ready);
		predict_item(cmd, pt, first, fin, words);
	endtask

	task automatic send_point(longint pt [JOINTS], logic first, logic fin);
		send_item(CMD_PLAN, pt, first, fin, WORDS_W'($urandom));
	endtask

	task automatic send_refill(logic [WORDS_W-1:0] words);
		longint junk [JOINTS];
		foreach (junk[j])
			junk[j] = longint'($signed(ANGLE_W'($urandom)));
		send_item(CMD_REFILL, junk, 1'($urandom), 1'($urandom), words);
	endtask

	// Refill asking for a given number of setpoints at the current fill goal.
	task automatic refill_for(int want);
		int w;
		w = (int'(fill_goal) - want) * 6 - $urandom_range(0, 5);
		send_refill(WORDS_W'(w < 0 ? 0 : w));
	endtask

	// Drop valid, wait for all setpoints, then let the sequencer go quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (setpoint_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TARGET_FILL:    fill_goal   = value & 32'h7F;
			CFG_FRAME_RATE:     servo_hz    = value & 32'h3FF;
			CFG_MAX_SPEED_BASE: speed_base  = value & 32'h7FFFFF;
			default:            speed_wrist = value & 32'h7FFFFF;
		endcase
	endtask

	task automatic set_regs(int unsigned tf, int unsigned fr, int unsigned mb, int unsigned mw);
		write_reg(CFG_TARGET_FILL, tf);
		write_reg(CFG_FRAME_RATE, fr);
		write_reg(CFG_MAX_SPEED_BASE, mb);
		write_reg(CFG_MAX_SPEED_WRIST, mw);
	endtask

	function automatic void near_point(ref longint pt [JOINTS], input longint from [JOINTS],
			int spread);
		longint v;
		for (int j = 0; j < JOINTS; j++) begin
			v = from[j] + $urandom_range(0, 2 * spread) - spread;
			if (v > 8388607)
				v = 8388607;
			if (v < -8388608)
				v = -8388608;
			pt[j] = v;
		end
	endfunction

	function automatic void wild_point(ref longint pt [JOINTS]);
		foreach (pt[j])
			pt[j] = longint'($signed(ANGLE_W'($urandom)));
	endfunction

	// Check each setpoint against the oldest prediction.
	always @(posedge clk) begin : check_setpoints
		int unsigned stall;
		setpoint_t   exp_sp;
		logic [ANGLE_W-1:0] got [JOINTS];
		if (out_valid && out_ready) begin
			got = '{out_a0, out_a1, out_a2, out_a3, out_a4, out_a5};
			if (setpoint_q.size() == 0) begin
				$display("%0t: unexpected setpoint, expected none, actual %h %h %h %h %h %h",
					$time, out_a0, out_a1, out_a2, out_a3, out_a4, out_a5);
				fail_count++;
			end else begin
				exp_sp = setpoint_q[0];
				setpoint_q.delete(0);
				for (int j = 0; j < JOINTS; j++)
					if (got[j] !== exp_sp.a[j]) begin
						$display("%0t: joint %0d expected %h actual %h",
							$time, j, exp_sp.a[j], got[j]);
						fail_count++;
					end
				if (batch_end !== exp_sp.last_of_batch) begin
					$display("%0t: batch_end expected %b actual %b",
						$time, exp_sp.last_of_batch, batch_end);
					fail_count++;
				end
				if (held !== exp_sp.repeat_flag) begin
					$display("%0t: held expected %b actual %b",
						$time, exp_sp.repeat_flag, held);
					fail_count++;
				end
			end
			stall = draw_gap();
		end else if (stall > 0) begin
			stall--;
		end
		out_ready <= arst_n && (stall == 0);
	end

	// Empty queue after reset: every setpoint repeats the zero pose.
	task automatic test_reset_hold();
		send_refill(16'd0);
		drain();
	endtask

	// A short plan with extreme angles and both flags together, walked at defaults.
	task automatic test_plan_walk();
		longint p [JOINTS];
		p = '{8388607, -8388608, 8388607, -8388608, 8388607, -8388608};
		send_point(p, 1'b1, 1'b1);
		refill_for(3);
		p = '{1000, -2000, 30000, -40000, 50000, 0};
		send_point(p, 1'b1, 1'b0);
		p = '{2000, -1000, 0, 0, 70000, -90000};
		send_point(p, 1'b0, 1'b0);
		p = '{0, 0, 0, 0, 0, 0};
		send_point(p, 1'b0, 1'b1);
		send_refill(16'd150);
		refill_for(6);
		refill_for(0);
		drain();
	endtask

	// Zero frame rate jumps in one part; zero speed limits act as a limit of one.
	task automatic test_zero_limits();
		longint p [JOINTS];
		set_regs(8, 0, 8388607, 8388607);
		p = '{-8388608, 8388607, 0, 5, -5, 100};
		send_point(p, 1'b1, 1'b0);
		p = '{8388607, -8388608, 1, 2, 3, 4};
		send_point(p, 1'b0, 1'b1);
		send_refill(16'd0);
		drain();
		set_regs(8, 1, 0, 0);
		p = '{3, -3, 1, 0, 2, -1};
		send_point(p, 1'b1, 1'b0);
		send_point(p, 1'b0, 1'b1);
		send_refill(16'd6);
		drain();
	endtask

	// Smallest and largest fill goals, cap of 64, and a full word count.
	task automatic test_fill_extremes();
		set_regs(1, 1000, 1, 8388607);
		send_refill(16'd0);
		send_refill(16'd1);
		send_refill(16'd65535);
		drain();
		set_regs(64, 200, 2722289, 3261257);
		send_refill(16'd0);
		drain();
		write_reg(CFG_TARGET_FILL, 127);
		send_refill(16'd5);
		drain();
	endtask

	// Overfill the queue: extra points drop, the closing one still sets the pose.
	task automatic test_queue_full();
		longint p [JOINTS];
		longint q [JOINTS];
		set_regs(6, 1000, 8388607, 8388607);
		q = '{0, 0, 0, 0, 0, 0};
		for (int i = 0; i < QUEUE_POINTS + 3; i++) begin
			near_point(p, q, 4000);
			send_point(p, i == 0, i == QUEUE_POINTS + 2);
			q = p;
		end
		send_refill(16'd0);
		drain();
	endtask

	// Mostly well-formed plans with refills, some noise and broken plans.
	task automatic test_random();
		longint p [JOINTS];
		int     len;
		int     refills;
		for (int phase = 0; phase < 6; phase++) begin
			gaps_on = (phase % 3 != 2);
			case (phase)
				0: set_regs(12, 200, 2722289, 3261257);
				1: set_regs($urandom_range(1, 64), $urandom_range(1, 1000),
					$urandom_range(1, 8388607), $urandom_range(1, 8388607));
				2: set_regs(20, 1000, 100000, 80000);
				3: set_regs(64, 1, 8388607, 1);
				4: set_regs($urandom_range(2, 16), $urandom_range(50, 500),
					$urandom_range(100000, 4000000), $urandom_range(100000, 4000000));
				default: set_regs(1, 700, 3000000, 2000000);
			endcase
			for (int plan = 0; plan < 5; plan++) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						wild_point(p);
					else
						near_point(p, last_sp, 30000);
					// Occasionally leave a plan unclosed or restart one midway.
					send_point(p, i == 0 || $urandom_range(0, 19) == 0,
						i == len - 1 && $urandom_range(0, 9) != 0);
				end
				refills = $urandom_range(1, 3);
				for (int r = 0; r < refills; r++)
					if ($urandom_range(0, 7) == 0)
						send_refill(WORDS_W'($urandom));
					else
						refill_for($urandom_range(0, 5));
			end
			drain();
		end
	endtask

	initial begin
		fail_count  = 0;
		idle_cycles = 0;
		gaps_on     = 1'b1;
		cfg_we = 1'b0;  cfg_idx = '0;  cfg_data = '0;
		in_valid = 1'b0;  command = CMD_PLAN;
		joint_a0 = '0;  joint_a1 = '0;  joint_a2 = '0;
		joint_a3 = '0;  joint_a4 = '0;  joint_a5 = '0;
		plan_first = 1'b0;  plan_last = 1'b0;  buffered_words = '0;
		out_ready = 1'b0;
		pt_head = 0;  pt_count = 0;
		foreach (last_sp[j])
			last_sp[j] = 0;
		batch_num = '0;  plan_batch = '0;
		fill_goal = TF_RESET;  servo_hz = FR_RESET;
		speed_base = MSB_RESET;  speed_wrist = MSW_RESET;
		@(posedge arst_n);
		@(posedge clk);
		test_reset_hold();
		test_plan_walk();
		test_zero_limits();
		test_fill_extremes();
		test_queue_full();
		test_random();
		if (fail_count == 0)
			$display("tb_joint_waypoint_feeder_core passed");
		else
			$display("tb_joint_waypoint_feeder_core failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/jwf_pkg.sv
hdl/jwf_div.sv
hdl/jwf_datapath.sv
hdl/jwf_ctrl.sv
hdl/joint_waypoint_feeder_core.sv
sim/tb_joint_waypoint_feeder_core.sv
